FILE: design/lcd_pkg.sv
`timescale 1ns / 1ps

package lcd_pkg;

	// Line capacity is LINE_DEPTH-1 characters.
	localparam int LINE_DEPTH = 32;
	localparam int LEN_W      = $clog2(LINE_DEPTH);

	// Only the first seven characters of a line take part in decoding
	// ("GAIN" plus three argument characters, or "STATUS").
	localparam int PREFIX_N = 7;
	localparam int PIDX_W   = $clog2(PREFIX_N);

	typedef logic [7:0]       char_t;
	typedef logic [LEN_W-1:0] len_t;

	localparam char_t CHAR_BS    = 8'h08;
	localparam char_t CHAR_LF    = 8'h0A;
	localparam char_t CHAR_CR    = 8'h0D;
	localparam char_t CHAR_SPACE = 8'h20;
	localparam char_t CHAR_DEL   = 8'h7F;
	localparam char_t CHAR_COMMA = 8'h2C;
	localparam char_t CHAR_ZERO  = 8'h30;
	localparam char_t CHAR_ONE   = 8'h31;
	localparam char_t CHAR_FOUR  = 8'h34;
	localparam char_t CHAR_SEVEN = 8'h37;
	localparam char_t CHAR_QMARK = 8'h3F;

	localparam logic KIND_ECHO = 1'b0;
	localparam logic KIND_CMD  = 1'b1;

	localparam logic [2:0] CMD_ROUTE  = 3'd0;
	localparam logic [2:0] CMD_GAIN   = 3'd1;
	localparam logic [2:0] CMD_STATUS = 3'd2;
	localparam logic [2:0] CMD_RESET  = 3'd3;
	localparam logic [2:0] CMD_HELP   = 3'd4;
	localparam logic [2:0] CMD_REJECT = 3'd5;

	localparam logic [3:0] ERR_NONE        = 4'd0;
	localparam logic [3:0] ERR_SHORT_ROUTE = 4'd1;
	localparam logic [3:0] ERR_BAD_OUTPUT  = 4'd2;
	localparam logic [3:0] ERR_NO_COMMA    = 4'd3;
	localparam logic [3:0] ERR_BAD_INPUT   = 4'd4;
	localparam logic [3:0] ERR_SHORT_GAIN  = 4'd5;
	localparam logic [3:0] ERR_BAD_CHANNEL = 4'd6;
	localparam logic [3:0] ERR_BAD_GAIN    = 4'd7;
	localparam logic [3:0] ERR_UNKNOWN     = 4'd8;

	localparam logic [2:0] IN_DISCONNECT = 3'd4;

	// Kinds of pending request held between the line logic and the output.
	localparam logic [1:0] REQ_ECHO  = 2'd0;
	localparam logic [1:0] REQ_ERASE = 2'd1;
	localparam logic [1:0] REQ_CMD   = 2'd2;

	typedef struct packed {
		logic [2:0] command;
		logic [1:0] first_arg;
		logic [2:0] second_arg;
		logic [3:0] error_code;
	} cmd_fields_t;

	typedef struct packed {
		logic [1:0]  kind;
		char_t       echo_char;
		cmd_fields_t cmd;
	} req_t;

	typedef struct packed {
		logic        result_kind;
		char_t       echo_char;
		cmd_fields_t cmd;
		logic        last_of_run;
	} result_t;

endpackage

FILE: design/lcd_decode.sv
`timescale 1ns / 1ps

module lcd_decode import lcd_pkg::*; (
	input  char_t       prefix [PREFIX_N],
	input  len_t        len,
	output cmd_fields_t fields
);

	function automatic char_t upcase(input char_t c);
		if (c >= 8'h61 && c <= 8'h7A) begin
			return c - 8'd32;
		end
		return c;
	endfunction

	logic  is_mux;
	logic  is_gain;
	logic  is_status;
	logic  is_reset;
	logic  is_help;
	char_t a0;
	char_t a1;
	char_t a2;
	char_t a2_up;
	logic  too_short;

	// Length checks come first so unused prefix entries never matter.
	assign is_mux = len >= LEN_W'(3) && upcase(prefix[0]) == "M" &&
		upcase(prefix[1]) == "U" && upcase(prefix[2]) == "X";
	assign is_gain = len >= LEN_W'(4) && upcase(prefix[0]) == "G" &&
		upcase(prefix[1]) == "A" && upcase(prefix[2]) == "I" &&
		upcase(prefix[3]) == "N";
	assign is_status = len == LEN_W'(6) && upcase(prefix[0]) == "S" &&
		upcase(prefix[1]) == "T" && upcase(prefix[2]) == "A" &&
		upcase(prefix[3]) == "T" && upcase(prefix[4]) == "U" &&
		upcase(prefix[5]) == "S";
	assign is_reset = len == LEN_W'(5) && upcase(prefix[0]) == "R" &&
		upcase(prefix[1]) == "E" && upcase(prefix[2]) == "S" &&
		upcase(prefix[3]) == "E" && upcase(prefix[4]) == "T";
	assign is_help = (len == LEN_W'(4) && upcase(prefix[0]) == "H" &&
		upcase(prefix[1]) == "E" && upcase(prefix[2]) == "L" &&
		upcase(prefix[3]) == "P") ||
		(len == LEN_W'(1) && prefix[0] == CHAR_QMARK);

	// Arguments start right after MUX or GAIN.
	assign a0        = is_mux ? prefix[3] : prefix[4];
	assign a1        = is_mux ? prefix[4] : prefix[5];
	assign a2        = is_mux ? prefix[5] : prefix[6];
	assign a2_up     = upcase(a2);
	assign too_short = is_mux ? (len < LEN_W'(6)) : (len < LEN_W'(7));

	always_comb begin
		fields = '0;
		priority if (is_mux || is_gain) begin
			priority if (too_short) begin
				fields.command    = CMD_REJECT;
				fields.error_code = is_mux ? ERR_SHORT_ROUTE : ERR_SHORT_GAIN;
			end else if (a0 < CHAR_ONE || a0 > CHAR_FOUR) begin
				fields.command    = CMD_REJECT;
				fields.error_code = is_mux ? ERR_BAD_OUTPUT : ERR_BAD_CHANNEL;
			end else if (a1 != CHAR_COMMA) begin
				fields.command    = CMD_REJECT;
				fields.error_code = ERR_NO_COMMA;
			end else if (is_mux) begin
				priority if (a2_up == "X") begin
					fields.command    = CMD_ROUTE;
					fields.first_arg  = 2'(a0 - CHAR_ONE);
					fields.second_arg = IN_DISCONNECT;
				end else if (a2_up >= CHAR_ONE && a2_up <= CHAR_FOUR) begin
					fields.command    = CMD_ROUTE;
					fields.first_arg  = 2'(a0 - CHAR_ONE);
					fields.second_arg = 3'(a2_up - CHAR_ONE);
				end else begin
					fields.command    = CMD_REJECT;
					fields.error_code = ERR_BAD_INPUT;
				end
			end else begin
				priority if (a2 >= CHAR_ZERO && a2 <= CHAR_SEVEN) begin
					fields.command    = CMD_GAIN;
					fields.first_arg  = 2'(a0 - CHAR_ONE);
					fields.second_arg = 3'(a2 - CHAR_ZERO);
				end else begin
					fields.command    = CMD_REJECT;
					fields.error_code = ERR_BAD_GAIN;
				end
			end
		end else if (is_status) begin
			fields.command = CMD_STATUS;
		end else if (is_reset) begin
			fields.command = CMD_RESET;
		end else if (is_help) begin
			fields.command = CMD_HELP;
		end else begin
			fields.command    = CMD_REJECT;
			fields.error_code = ERR_UNKNOWN;
		end
	end

endmodule

FILE: design/lcd_line.sv
`timescale 1ns / 1ps

module lcd_line import lcd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  char_t rx_char,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  req_valid,
	output req_t  req,
	input  logic  req_done
);

	len_t        len_q;
	char_t       prefix_q [PREFIX_N];
	logic        req_valid_s1;
	req_t        req_s1;
	cmd_fields_t dec_fields;
	logic        accept;
	logic        is_end;
	logic        is_erase;
	logic        has_room;
	logic        new_req;
	req_t        new_req_data;

	lcd_decode u_decode (
		.prefix (prefix_q),
		.len    (len_q),
		.fields (dec_fields)
	);

	assign in_ready = !req_valid_s1 || req_done;
	assign accept   = in_valid && in_ready;
	assign is_end   = rx_char == CHAR_CR || rx_char == CHAR_LF;
	assign is_erase = rx_char == CHAR_BS || rx_char == CHAR_DEL;
	assign has_room = len_q < LEN_W'(LINE_DEPTH - 1);

	always_comb begin
		new_req_data = '0;
		priority if (is_end) begin
			new_req           = len_q != '0;
			new_req_data.kind = REQ_CMD;
			new_req_data.cmd  = dec_fields;
		end else if (is_erase) begin
			new_req           = len_q != '0;
			new_req_data.kind = REQ_ERASE;
		end else begin
			new_req                = has_room;
			new_req_data.kind      = REQ_ECHO;
			new_req_data.echo_char = rx_char;
		end
	end

	// Characters beyond the decoded prefix are never looked at again, so
	// only the count is kept for them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			for (int i = 0; i < PREFIX_N; i++) begin
				prefix_q[i] <= '0;
			end
		end else if (accept) begin
			priority if (is_end) begin
				len_q <= '0;
			end else if (is_erase) begin
				if (len_q != '0) begin
					len_q <= len_q - LEN_W'(1);
				end
			end else if (has_room) begin
				if (len_q < LEN_W'(PREFIX_N)) begin
					prefix_q[len_q[PIDX_W-1:0]] <= rx_char;
				end
				len_q <= len_q + LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (accept && new_req) begin
			req_valid_s1 <= 1'b1;
		end else if (req_done) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && new_req) begin
			req_s1 <= new_req_data;
		end
	end

	assign req_valid = req_valid_s1;
	assign req       = req_s1;

endmodule

FILE: design/lcd_emit.sv
`timescale 1ns / 1ps

module lcd_emit import lcd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	input  req_t    req,
	output logic    req_done,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t result
);

	logic    out_valid_q;
	result_t out_q;
	logic    [1:0] beat_q;
	logic    load;
	logic    erase;
	result_t next_out;

	assign load     = req_valid && (!out_valid_q || out_ready);
	assign erase    = req.kind == REQ_ERASE;
	assign req_done = load && (!erase || beat_q == 2'd2);

	always_comb begin
		next_out = '0;
		unique case (req.kind)
			REQ_ECHO: begin
				next_out.result_kind = KIND_ECHO;
				next_out.echo_char   = req.echo_char;
				next_out.last_of_run = 1'b1;
			end
			REQ_ERASE: begin
				// An erase shows as backspace, space, backspace.
				next_out.result_kind = KIND_ECHO;
				next_out.echo_char   = (beat_q == 2'd1) ? CHAR_SPACE : CHAR_BS;
				next_out.last_of_run = beat_q == 2'd2;
			end
			REQ_CMD: begin
				next_out.result_kind = KIND_CMD;
				next_out.cmd         = req.cmd;
				next_out.last_of_run = 1'b1;
			end
			default: begin
				next_out.result_kind = KIND_ECHO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			beat_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (req_done) begin
				beat_q <= '0;
			end else if (load && erase) begin
				beat_q <= beat_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= next_out;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = out_q;

`ifndef SYNTHESIS
	a_beat_mid_erase: assert property (@(posedge clk) disable iff (!arst_n)
		beat_q != 2'd0 |-> req_valid && req.kind == REQ_ERASE)
		else $error("erase sequence lost its request");

	a_beat_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		beat_q != 2'd0 |-> out_valid_q && !out_q.last_of_run)
		else $error("erase sequence ended early");

	a_cmd_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.result_kind == KIND_CMD |-> out_q.last_of_run)
		else $error("command result not marked last");

	a_reject_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.result_kind == KIND_CMD |->
		((out_q.cmd.command == CMD_REJECT) == (out_q.cmd.error_code != ERR_NONE)))
		else $error("error code does not match command");
`endif

endmodule

FILE: design/line_command_decoder_core.sv
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// input     in_valid / in_ready   rx_char
// output    out_valid / out_ready result_kind, echo_char, command, first_arg,
//                                 second_arg, error_code, last_of_run
//
// A character is decoded in the cycle it is accepted; its result is held in
// the request register and then loaded into the output register. An erase
// gives three results (one per echoed character), any other request one.
// A new character is taken each cycle while the output drains, limited by the
// single request register between the line logic and the output register.
// Reset clears the line length and all valid state; no clearing pass.

module line_command_decoder_core import lcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       result_kind,
	output logic [7:0] echo_char,
	output logic [2:0] command,
	output logic [1:0] first_arg,
	output logic [2:0] second_arg,
	output logic [3:0] error_code,
	output logic       last_of_run
);

	logic    req_valid;
	req_t    req;
	logic    req_done;
	result_t result;

	lcd_line u_line (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_char   (rx_char),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_valid (req_valid),
		.req       (req),
		.req_done  (req_done)
	);

	lcd_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_done  (req_done),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	assign result_kind = result.result_kind;
	assign echo_char   = result.echo_char;
	assign command     = result.cmd.command;
	assign first_arg   = result.cmd.first_arg;
	assign second_arg  = result.cmd.second_arg;
	assign error_code  = result.cmd.error_code;
	assign last_of_run = result.last_of_run;

endmodule

FILE: bench/lcd_checker.sv
`timescale 1ns / 1ps

module lcd_checker import lcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] rx_char,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       result_kind,
	input  logic [7:0] echo_char,
	input  logic [2:0] command,
	input  logic [1:0] first_arg,
	input  logic [2:0] second_arg,
	input  logic [3:0] error_code,
	input  logic       last_of_run,
	output int         errors,
	output int         outstanding,
	output int         results_seen,
	output int         commands_seen,
	output int         rejects_seen
);

	localparam char_t LETTER_X    = "X";
	localparam int    PRINT_LIMIT = 30;

	char_t   line_buf [LINE_DEPTH];
	int      line_len;
	result_t expected_results [$];

	function automatic char_t to_upper(char_t c);
		return (c >= "a" && c <= "z") ? c - 8'h20 : c;
	endfunction

	function automatic bit line_begins(string w);
		if (line_len < w.len())
			return 1'b0;
		for (int i = 0; i < w.len(); i++)
			if (to_upper(line_buf[i]) != char_t'(w[i]))
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic bit line_is(string w);
		return line_len == w.len() && line_begins(w);
	endfunction

	function automatic cmd_fields_t bare_cmd(logic [2:0] cmd, logic [3:0] err);
		cmd_fields_t f;
		f = '0;
		f.command = cmd;
		f.error_code = err;
		return f;
	endfunction

	// Arguments of MUX and GAIN start at base; anything past the third
	// argument character is ignored.
	function automatic cmd_fields_t decode_pair(int base, bit is_mux);
		cmd_fields_t f;
		char_t a0, a1, a2;
		if (line_len - base < 3)
			return bare_cmd(CMD_REJECT, is_mux ? ERR_SHORT_ROUTE : ERR_SHORT_GAIN);
		a0 = line_buf[base];
		a1 = line_buf[base + 1];
		a2 = line_buf[base + 2];
		if (a0 < CHAR_ONE || a0 > CHAR_FOUR)
			return bare_cmd(CMD_REJECT, is_mux ? ERR_BAD_OUTPUT : ERR_BAD_CHANNEL);
		if (a1 != CHAR_COMMA)
			return bare_cmd(CMD_REJECT, ERR_NO_COMMA);
		f = bare_cmd(is_mux ? CMD_ROUTE : CMD_GAIN, ERR_NONE);
		f.first_arg = 2'(a0 - CHAR_ONE);
		if (is_mux) begin
			if (to_upper(a2) == LETTER_X)
				f.second_arg = IN_DISCONNECT;
			else if (a2 >= CHAR_ONE && a2 <= CHAR_FOUR)
				f.second_arg = 3'(a2 - CHAR_ONE);
			else
				f = bare_cmd(CMD_REJECT, ERR_BAD_INPUT);
		end else if (a2 >= CHAR_ZERO && a2 <= CHAR_SEVEN) begin
			f.second_arg = 3'(a2 - CHAR_ZERO);
		end else begin
			f = bare_cmd(CMD_REJECT, ERR_BAD_GAIN);
		end
		return f;
	endfunction

	function automatic cmd_fields_t decode_line();
		if (line_begins("MUX"))
			return decode_pair(3, 1'b1);
		if (line_begins("GAIN"))
			return decode_pair(4, 1'b0);
		if (line_is("STATUS"))
			return bare_cmd(CMD_STATUS, ERR_NONE);
		if (line_is("RESET"))
			return bare_cmd(CMD_RESET, ERR_NONE);
		if (line_is("HELP") || line_is("?"))
			return bare_cmd(CMD_HELP, ERR_NONE);
		return bare_cmd(CMD_REJECT, ERR_UNKNOWN);
	endfunction

	function automatic result_t echo_of(char_t c, logic last);
		result_t r;
		r = '0;
		r.result_kind = KIND_ECHO;
		r.echo_char = c;
		r.last_of_run = last;
		return r;
	endfunction

	// Updates the line and queues whatever the character should produce.
	task automatic decode_char(char_t c);
		result_t r;
		if (c == CHAR_CR || c == CHAR_LF) begin
			if (line_len != 0) begin
				r = '0;
				r.result_kind = KIND_CMD;
				r.cmd = decode_line();
				r.last_of_run = 1'b1;
				expected_results.push_back(r);
				line_len = 0;
			end
		end else if (c == CHAR_BS || c == CHAR_DEL) begin
			if (line_len != 0) begin
				line_len--;
				expected_results.push_back(echo_of(CHAR_BS, 1'b0));
				expected_results.push_back(echo_of(CHAR_SPACE, 1'b0));
				expected_results.push_back(echo_of(CHAR_BS, 1'b1));
			end
		end else if (line_len < LINE_DEPTH - 1) begin
			line_buf[line_len] = c;
			line_len++;
			expected_results.push_back(echo_of(c, 1'b1));
		end
	endtask

	task automatic report(string msg);
		if (errors < PRINT_LIMIT)
			$display("[%0t] %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report($sformatf("result %0d: %s is %0h, expected %0h",
				results_seen, name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		result_t want;
		if (!arst_n) begin
			line_len = 0;
			expected_results.delete();
			errors = 0;
			outstanding = 0;
			results_seen = 0;
			commands_seen = 0;
			rejects_seen = 0;
		end else begin
			// The request is taken first so that a same-cycle result still
			// meets the oldest expectation at the head of the queue.
			if (in_valid && in_ready)
				decode_char(rx_char);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report($sformatf("result %0d arrived with nothing expected",
						results_seen));
				end else begin
					want = expected_results.pop_front();
					check_field("result_kind", 8'(result_kind), 8'(want.result_kind));
					check_field("echo_char", echo_char, want.echo_char);
					check_field("command", 8'(command), 8'(want.cmd.command));
					check_field("first_arg", 8'(first_arg), 8'(want.cmd.first_arg));
					check_field("second_arg", 8'(second_arg),
						8'(want.cmd.second_arg));
					check_field("error_code", 8'(error_code),
						8'(want.cmd.error_code));
					check_field("last_of_run", 8'(last_of_run), 8'(want.last_of_run));
					if (want.result_kind == KIND_CMD) begin
						commands_seen++;
						if (want.cmd.command == CMD_REJECT)
							rejects_seen++;
					end
				end
				results_seen++;
			end
			outstanding = expected_results.size();
		end
	end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import lcd_pkg::*;

	localparam int RANDOM_ITEMS = 350;
	localparam int QUIET_TAIL   = 40;
	localparam int HOLD_AT      = 100;
	localparam int PAUSE_AT     = 220;
	localparam int HOLD_CYCLES  = 200;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 20;

	typedef enum {
		LINE_ROUTE, LINE_GAIN, LINE_WORD, LINE_BAD_PAIR,
		LINE_UNKNOWN, LINE_NOISE, LINE_LONG
	} line_kind_t;

	typedef enum {FLAW_SHORT, FLAW_FIRST, FLAW_COMMA, FLAW_SECOND} pair_flaw_t;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] rx_char   = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       result_kind;
	logic [7:0] echo_char;
	logic [2:0] command;
	logic [1:0] first_arg;
	logic [2:0] second_arg;
	logic [3:0] error_code;
	logic       last_of_run;

	int errors, outstanding, results_seen, commands_seen, rejects_seen;

	bit    quiet;
	bit    calm;
	bit    hold_req;
	int    hold_left;
	int    items_sent;
	char_t line_q [$];

	line_command_decoder_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_char     (rx_char),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.echo_char   (echo_char),
		.command     (command),
		.first_arg   (first_arg),
		.second_arg  (second_arg),
		.error_code  (error_code),
		.last_of_run (last_of_run)
	);

	lcd_checker decode_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_char       (rx_char),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.echo_char     (echo_char),
		.command       (command),
		.first_arg     (first_arg),
		.second_arg    (second_arg),
		.error_code    (error_code),
		.last_of_run   (last_of_run),
		.errors        (errors),
		.outstanding   (outstanding),
		.results_seen  (results_seen),
		.commands_seen (commands_seen),
		.rejects_seen  (rejects_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result side: random stall bursts, calm stretches, and one long hold
	// that backs the block up into its input.
	initial begin : result_side
		int stall;
		int cycle;
		bit calm_rx;
		stall = 0;
		cycle = 0;
		calm_rx = 1'b0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle % 50 == 0)
				calm_rx = ($urandom_range(0, 2) == 0);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (!quiet && !calm_rx && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 10) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Timeout: nothing moved for %0d cycles.", IDLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// Valid stays high across back-to-back requests; within this task it is only
	// lowered when a gap is inserted.
	task automatic send_char(char_t c);
		int gap;
		if (!quiet && !calm && !hold_req && hold_left == 0 &&
			$urandom_range(0, 6) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_char <= c;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic char_t any_printable();
		return char_t'($urandom_range(8'h20, 8'h7E));
	endfunction

	// Now and then a stray character is typed and erased before the real one.
	task automatic push_typed(char_t c);
		if ($urandom_range(0, 9) == 0) begin
			line_q.push_back(any_printable());
			line_q.push_back($urandom_range(0, 1) ? CHAR_BS : CHAR_DEL);
		end
		line_q.push_back(c);
	endtask

	task automatic push_word(string w);
		char_t c;
		for (int i = 0; i < w.len(); i++) begin
			c = w[i];
			if (c >= "A" && c <= "Z" && $urandom_range(0, 1))
				c = c + 8'h20;
			push_typed(c);
		end
	endtask

	task automatic push_command_word();
		case ($urandom_range(0, 3))
			0: push_word("STATUS");
			1: push_word("RESET");
			2: push_word("HELP");
			default: push_word("?");
		endcase
	endtask

	task automatic build_line();
		line_kind_t kind;
		pair_flaw_t flaw;
		bit         is_mux;
		int         n;
		char_t      c;
		line_q.delete();
		n = $urandom_range(0, 99);
		if (n < 22)      kind = LINE_ROUTE;
		else if (n < 40) kind = LINE_GAIN;
		else if (n < 56) kind = LINE_WORD;
		else if (n < 76) kind = LINE_BAD_PAIR;
		else if (n < 85) kind = LINE_UNKNOWN;
		else if (n < 96) kind = LINE_NOISE;
		else             kind = LINE_LONG;

		case (kind)
			LINE_ROUTE: begin
				push_word("MUX");
				push_typed(char_t'(CHAR_ONE + $urandom_range(0, 3)));
				push_typed(CHAR_COMMA);
				n = $urandom_range(0, 4);
				if (n == 4)
					push_typed($urandom_range(0, 1) ? "X" : "x");
				else
					push_typed(char_t'(CHAR_ONE + n));
			end
			LINE_GAIN: begin
				push_word("GAIN");
				push_typed(char_t'(CHAR_ONE + $urandom_range(0, 3)));
				push_typed(CHAR_COMMA);
				push_typed(char_t'(CHAR_ZERO + $urandom_range(0, 7)));
			end
			LINE_WORD: push_command_word();
			LINE_BAD_PAIR: begin
				is_mux = bit'($urandom_range(0, 1));
				push_word(is_mux ? "MUX" : "GAIN");
				flaw = pair_flaw_t'($urandom_range(0, 3));
				if (flaw == FLAW_SHORT) begin
					n = $urandom_range(0, 2);
					if (n >= 1)
						push_typed(char_t'(CHAR_ONE + $urandom_range(0, 3)));
					if (n >= 2)
						push_typed(CHAR_COMMA);
				end else begin
					if (flaw == FLAW_FIRST) begin
						do c = any_printable(); while (c >= CHAR_ONE && c <= CHAR_FOUR);
						push_typed(c);
					end else begin
						push_typed(char_t'(CHAR_ONE + $urandom_range(0, 3)));
					end
					if (flaw == FLAW_COMMA) begin
						do c = any_printable(); while (c == CHAR_COMMA);
						push_typed(c);
					end else begin
						push_typed(CHAR_COMMA);
					end
					if (flaw == FLAW_SECOND) begin
						if (is_mux)
							do c = any_printable();
							while ((c >= CHAR_ONE && c <= CHAR_FOUR) || c == "X" || c == "x");
						else
							do c = any_printable(); while (c >= CHAR_ZERO && c <= CHAR_SEVEN);
						push_typed(c);
					end else begin
						push_typed(any_printable());
					end
				end
			end
			LINE_UNKNOWN: begin
				// Either a known word with something after it, or random letters.
				if ($urandom_range(0, 1)) begin
					push_command_word();
					push_typed(any_printable());
				end else begin
					repeat ($urandom_range(1, 7))
						push_word(string'(char_t'($urandom_range(8'h41, 8'h5A))));
				end
			end
			LINE_NOISE: begin
				repeat ($urandom_range(1, 12)) begin
					if ($urandom_range(0, 3) == 0) begin
						case ($urandom_range(0, 3))
							0: c = CHAR_BS;
							1: c = CHAR_DEL;
							2: c = CHAR_CR;
							default: c = CHAR_LF;
						endcase
					end else begin
						c = char_t'($urandom_range(0, 255));
					end
					line_q.push_back(c);
				end
			end
			LINE_LONG: begin
				if ($urandom_range(0, 1))
					push_word("MUX2,3");
				n = $urandom_range(LINE_DEPTH - 3, LINE_DEPTH + 4);
				while (line_q.size() < n)
					line_q.push_back(any_printable());
			end
		endcase
		if (kind != LINE_NOISE || $urandom_range(0, 1))
			line_q.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
	endtask

	initial begin : stimulus
		int  random_start;
		bit  held;
		bit  paused;
		held = 1'b0;
		paused = 1'b0;
		quiet = 1'b0;
		calm = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		items_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Erase and line end on an empty line, the lone question mark, the
		// byte extremes typed and erased, then mixed-case route and gain.
		send_char(CHAR_BS);
		send_char(CHAR_CR);
		send_text("?");
		send_char(CHAR_LF);
		send_char(8'h00);
		send_char(8'hFF);
		send_char(CHAR_DEL);
		send_char(CHAR_BS);
		send_text("mUx4,X");
		send_char(CHAR_CR);
		send_text("gAin1,7");
		send_char(CHAR_LF);
		drain();

		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			if (items_sent - random_start >= RANDOM_ITEMS - QUIET_TAIL)
				quiet = 1'b1;
			if (!held && items_sent - random_start >= HOLD_AT) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			if (!paused && items_sent - random_start >= PAUSE_AT) begin
				drain();
				paused = 1'b1;
			end
			calm = ($urandom_range(0, 3) == 0);
			build_line();
			foreach (line_q[i])
				send_char(line_q[i]);
		end
		in_valid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d characters: edits, every command, %s",
			items_sent, "malformed and overlong lines, raw bytes.");
		$display("Checked %0d results, %0d of them commands, %0d of those rejected.",
			results_seen, commands_seen, rejects_seen);
		if (errors == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
